// ===== rtl/gda_pkg.sv =====
// ----------------------------------------------------------------------------
// gda_pkg
// Shared types, constants and calendar functions of the Gregorian date adder.
// ----------------------------------------------------------------------------
package gda_pkg;

  localparam int unsigned YEAR_BITS_DEF = 16;

  // Width of a day count: a week amount times seven still fits.
  localparam int unsigned REM_BITS = 18;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [4:0] DAY_FIRST = 5'd1;
  localparam logic [4:0] DAY_LAST_DEC = 5'd31;
  localparam logic [4:0] FEB_LEAP_LEN = 5'd29;

  // The residue of the year modulo 25 settles the century rules together
  // with the low year bits.
  localparam logic [4:0] RES_MOD = 5'd25;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [1:0] {
    REQ_DAYS   = 2'd0,
    REQ_WEEKS  = 2'd1,
    REQ_MONTHS = 2'd2,
    REQ_YEARS  = 2'd3
  } req_type_t;

  // Control of the modulo 25 residue unit.
  typedef struct packed {
    logic start;
    logic inc;
  } res_ctl_t;

  // Divisible by 4 and not by 100, or divisible by 400. With r = y mod 25,
  // y mod 100 == 0 is y mod 4 == 0 and r == 0, y mod 400 == 0 is
  // y mod 16 == 0 and r == 0.
  function automatic logic gda_leap(input logic [3:0] ylo, input logic [4:0] res);
    logic by4;
    logic by16;
    by4  = (ylo[1:0] == 2'd0);
    by16 = (ylo == 4'd0);
    return (by4 && (res != 5'd0)) || (by16 && (res == 5'd0));
  endfunction

  // Length of a month; zero for a month code outside 1..12.
  function automatic logic [4:0] gda_month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    if (month == 4'd0 || month > MONTH_DEC) begin
      len = 5'd0;
    end else if (month == MONTH_FEB && leap) begin
      len = FEB_LEAP_LEN;
    end else begin
      len = MONTH_LEN[month - 4'd1];
    end
    return len;
  endfunction

endpackage

// ===== rtl/gda_mod25.sv =====
// ----------------------------------------------------------------------------
// gda_mod25
// Year residue modulo 25: found by a reciprocal multiplication after a load,
// then kept in step with year increments.
// ----------------------------------------------------------------------------
module gda_mod25 #(
  parameter int unsigned YEAR_BITS = gda_pkg::YEAR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gda_pkg::res_ctl_t     ctl,
  input  logic [YEAR_BITS-1:0]  year_in,
  output logic [4:0]            res,
  output logic [4:0]            res_inc,
  output logic                  busy
);
  import gda_pkg::*;

  // floor(y / 25) equals (y * RECIP_25) >> RECIP_SHIFT for every y below 2^32.
  localparam logic [31:0] RECIP_25    = 32'd1374389535;
  localparam int unsigned RECIP_SHIFT = 35;

  logic [31:0] y_ld_r;
  logic [4:0]  q_lo_r;
  logic        q_done_r;
  logic [4:0]  r_r;
  logic        busy_r;
  logic [63:0] prod;
  logic [4:0]  q25_lo;

  // The remainder is below 32, so y - 25q can be formed modulo 32 and only
  // the low five bits of the quotient are needed.
  always_comb begin
    prod   = 64'(y_ld_r) * 64'(RECIP_25);
    q25_lo = (q_lo_r << 4) + (q_lo_r << 3) + q_lo_r;
  end

  assign res_inc = (r_r == RES_MOD - 5'd1) ? 5'd0 : r_r + 5'd1;
  assign res     = r_r;
  assign busy    = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (ctl.start) begin
      busy_r   <= 1'b1;
      q_done_r <= 1'b0;
      y_ld_r   <= 32'(year_in);
    end else if (busy_r) begin
      if (!q_done_r) begin
        q_lo_r   <= prod[RECIP_SHIFT+4:RECIP_SHIFT];
        q_done_r <= 1'b1;
      end else begin
        r_r    <= y_ld_r[4:0] - q25_lo;
        busy_r <= 1'b0;
      end
    end else if (ctl.inc) begin
      r_r <= res_inc;
    end
  end

endmodule

// ===== rtl/gregorian_date_adder.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_adder
// Advances a Gregorian date by a number of days, weeks, months or years.
// ----------------------------------------------------------------------------
// Input channel in_*: a request carries the unit, the amount and the start
// date. Result channel out_*: the new date with overflow and bad-date flags.
// Both channels move a transaction when valid is high and stall is low.
// One request is worked at a time; in_stall is high from acceptance until
// the result has been written to the output register.
// After acceptance the block finds the year modulo 25 (reciprocal
// multiply, remainder, hand-over), checks the start date, runs the
// stepping loop and then writes the result.
// Days and weeks step once per month boundary crossed, months once per
// month added; years skip the loop and are added in the check state.
// The loop runs on one shared day/month step unit.
// A finished result waits in the output register while out_stall is high;
// the next request can be taken meanwhile, but its result is held back
// until the register frees. Reset drops any request in flight and clears
// out_valid.
// ----------------------------------------------------------------------------
module gregorian_date_adder #(
  parameter int unsigned YEAR_BITS = gda_pkg::YEAR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_req_type,
  input  logic [14:0]           in_amount,
  input  logic [4:0]            in_start_day,
  input  logic [3:0]            in_start_month,
  input  logic [YEAR_BITS-1:0]  in_start_year,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [4:0]            out_new_day,
  output logic [3:0]            out_new_month,
  output logic [YEAR_BITS-1:0]  out_new_year,
  output logic                  out_year_overflow,
  output logic                  out_bad_date
);
  import gda_pkg::*;

  localparam int unsigned SW = ((YEAR_BITS > 15) ? YEAR_BITS : 15) + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RESID,
    ST_CHECK,
    ST_DAYS,
    ST_MONTHS,
    ST_FINISH
  } state_t;

  state_t                state_r;
  req_type_t             kind_r;
  logic [14:0]           amt_r;
  logic [REM_BITS-1:0]   rem_r;
  logic [4:0]            d_r;
  logic [3:0]            m_r;
  logic [YEAR_BITS-1:0]  y_r;
  logic                  ovf_r;
  logic                  bad_r;

  logic                  out_valid_r;
  logic [4:0]            out_day_r;
  logic [3:0]            out_month_r;
  logic [YEAR_BITS-1:0]  out_year_r;
  logic                  out_ovf_r;
  logic                  out_bad_r;

  res_ctl_t              res_ctl;
  logic [4:0]            res;
  logic [4:0]            res_inc;
  logic                  res_busy;

  logic                  in_acc;
  logic                  at_dec;
  logic                  y_max;
  logic [4:0]            len_cur;
  logic [3:0]            m_next;
  logic [YEAR_BITS-1:0]  y_next;
  logic [4:0]            len_next;
  logic [REM_BITS:0]     d_sum;
  logic                  fits;
  logic [REM_BITS-1:0]   week_days;
  logic [SW-1:0]         y_sum;
  logic                  y_over;
  logic                  out_free;

  gda_mod25 #(
    .YEAR_BITS (YEAR_BITS)
  ) u_mod25 (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (res_ctl),
    .year_in (in_start_year),
    .res     (res),
    .res_inc (res_inc),
    .busy    (res_busy)
  );

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Shared step unit: current month length, the following month and its
  // length, and the day-fit test.
  always_comb begin
    at_dec    = (m_r == MONTH_DEC);
    y_max     = &y_r;
    len_cur   = gda_month_len(m_r, gda_leap(y_r[3:0], res));
    m_next    = at_dec ? MONTH_JAN : m_r + 4'd1;
    y_next    = at_dec ? y_r + YEAR_BITS'(1) : y_r;
    len_next  = gda_month_len(m_next, gda_leap(y_next[3:0], at_dec ? res_inc : res));
    d_sum     = (REM_BITS + 1)'(d_r) + (REM_BITS + 1)'(rem_r);
    fits      = (d_sum <= (REM_BITS + 1)'(len_cur));
    week_days = (REM_BITS'(amt_r) << 3) - REM_BITS'(amt_r);
    y_sum     = SW'(y_r) + SW'(amt_r);
    y_over    = (y_sum > SW'({YEAR_BITS{1'b1}}));
  end

  always_comb begin
    res_ctl.start = in_acc;
    res_ctl.inc   = 1'b0;
    if (state_r == ST_DAYS && rem_r != '0 && !fits && at_dec && !y_max) begin
      res_ctl.inc = 1'b1;
    end
    if (state_r == ST_MONTHS && amt_r != '0 && at_dec && !y_max) begin
      res_ctl.inc = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != ST_FINISH) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            kind_r  <= req_type_t'(in_req_type);
            amt_r   <= in_amount;
            d_r     <= in_start_day;
            m_r     <= in_start_month;
            y_r     <= in_start_year;
            ovf_r   <= 1'b0;
            bad_r   <= 1'b0;
            state_r <= ST_RESID;
          end
        end
        ST_RESID: begin
          if (!res_busy) begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (d_r == 5'd0 || d_r > len_cur) begin
            bad_r   <= 1'b1;
            state_r <= ST_FINISH;
          end else begin
            unique case (kind_r)
              REQ_DAYS: begin
                rem_r   <= REM_BITS'(amt_r);
                state_r <= ST_DAYS;
              end
              REQ_WEEKS: begin
                rem_r   <= week_days;
                state_r <= ST_DAYS;
              end
              REQ_MONTHS: begin
                state_r <= ST_MONTHS;
              end
              REQ_YEARS: begin
                if (y_over) begin
                  y_r   <= {YEAR_BITS{1'b1}};
                  ovf_r <= 1'b1;
                end else begin
                  y_r <= y_sum[YEAR_BITS-1:0];
                end
                state_r <= ST_FINISH;
              end
              default: state_r <= ST_FINISH;
            endcase
          end
        end
        ST_DAYS: begin
          if (rem_r == '0) begin
            state_r <= ST_FINISH;
          end else if (fits) begin
            d_r     <= d_sum[4:0];
            rem_r   <= '0;
            state_r <= ST_FINISH;
          end else if (at_dec && y_max) begin
            // Past the last day of the largest year: saturate.
            d_r     <= DAY_LAST_DEC;
            ovf_r   <= 1'b1;
            state_r <= ST_FINISH;
          end else begin
            rem_r <= rem_r - REM_BITS'(len_cur - d_r + 5'd1);
            d_r   <= DAY_FIRST;
            m_r   <= m_next;
            y_r   <= y_next;
          end
        end
        ST_MONTHS: begin
          if (amt_r == '0) begin
            state_r <= ST_FINISH;
          end else if (at_dec && y_max) begin
            ovf_r   <= 1'b1;
            state_r <= ST_FINISH;
          end else begin
            m_r   <= m_next;
            y_r   <= y_next;
            amt_r <= amt_r - 15'd1;
            if (d_r > len_next) begin
              d_r <= len_next;
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_day_r   <= d_r;
            out_month_r <= m_r;
            out_year_r  <= y_r;
            out_ovf_r   <= ovf_r;
            out_bad_r   <= bad_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_new_day       = out_day_r;
  assign out_new_month     = out_month_r;
  assign out_new_year      = out_year_r;
  assign out_year_overflow = out_ovf_r;
  assign out_bad_date      = out_bad_r;

  // A rejected start date never reports a year overflow.
  a_bad_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_date |-> !out_year_overflow)
    else $error("bad date result carries an overflow flag");

  // A good result always holds a month in 1..12 and a nonzero day.
  a_good_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bad_date |->
      (out_new_month >= MONTH_JAN) && (out_new_month <= MONTH_DEC) &&
      (out_new_day != 5'd0))
    else $error("result date out of range");

  // An accepted request keeps the input side closed on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a transaction");

  // The residue unit is loaded only on a transaction and never mid-loop.
  a_res_idle_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DAYS || state_r == ST_MONTHS) |-> !res_busy && !res_ctl.start)
    else $error("residue unit active during the step loop");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Gregorian date adder. A queue of requests (a
// directed set of calendar corner cases, then mostly valid random dates with
// some malformed ones) feeds a handshake driver. A monitor compares every
// result field against a date predictor that runs when each request is taken.
// ----------------------------------------------------------------------------
module tb_top;

  import gda_pkg::*;

  localparam int unsigned YEAR_BITS = YEAR_BITS_DEF;
  localparam int unsigned YEAR_MAX = (1 << YEAR_BITS) - 1;
  localparam int unsigned AMOUNT_MAX = 32767;
  localparam int unsigned LAST_MONTH = 12;
  localparam int unsigned LAST_DAY_DEC = 31;
  localparam int unsigned RANDOM_REQS = 650;
  localparam int unsigned TAIL_REQS = 60;
  localparam int unsigned LONG_HOLD = 600;
  localparam int unsigned HOLD_AFTER = 3000;
  localparam int unsigned IDLE_LIMIT = 200000;
  localparam int unsigned TAIL_CYCLES = 64;
  localparam int unsigned MAX_PRINTED = 40;

  localparam int unsigned DAYS_PER_MONTH [12] = '{
    31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
  };

  typedef struct {
    req_type_t              kind;
    logic [14:0]            amount;
    logic [4:0]             day;
    logic [3:0]             month;
    logic [YEAR_BITS-1:0]   year;
    bit                     drain_first;
  } date_req_t;

  typedef struct {
    logic [4:0]             day;
    logic [3:0]             month;
    logic [YEAR_BITS-1:0]   year;
    logic                   overflow;
    logic                   bad;
  } date_res_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_req_type = '0;
  logic [14:0]           in_amount = '0;
  logic [4:0]            in_start_day = '0;
  logic [3:0]            in_start_month = '0;
  logic [YEAR_BITS-1:0]  in_start_year = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [4:0]            out_new_day;
  logic [3:0]            out_new_month;
  logic [YEAR_BITS-1:0]  out_new_year;
  logic                  out_year_overflow;
  logic                  out_bad_date;

  date_req_t pending_reqs [$];
  date_res_t expected_dates [$];

  int unsigned reqs_taken = 0;
  int unsigned results_seen = 0;
  int unsigned bad_seen = 0;
  int unsigned overflow_seen = 0;
  int unsigned error_count = 0;
  int unsigned total_reqs = 0;
  int unsigned directed_reqs = 0;
  int unsigned sender_gap = 0;
  int unsigned stall_left = 0;
  int unsigned stall_tick = 0;
  int unsigned idle_cycles = 0;
  logic        quiet_tail = 1'b0;
  logic        long_hold_done = 1'b0;

  gregorian_date_adder #(
    .YEAR_BITS(YEAR_BITS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_amount        (in_amount),
    .in_start_day     (in_start_day),
    .in_start_month   (in_start_month),
    .in_start_year    (in_start_year),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_new_day      (out_new_day),
    .out_new_month    (out_new_month),
    .out_new_year     (out_new_year),
    .out_year_overflow(out_year_overflow),
    .out_bad_date     (out_bad_date)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit is_leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in(int unsigned m, int unsigned y);
    if (m < 1 || m > LAST_MONTH) begin
      return 0;
    end
    if (m == 2) begin
      return is_leap_year(y) ? 29 : 28;
    end
    return DAYS_PER_MONTH[m - 1];
  endfunction

  // Walks the calendar the same way the block does: whole months at a time
  // for day counts, single steps with day clamping for month counts.
  function automatic date_res_t advance_date(date_req_t r);
    date_res_t   res;
    int unsigned d;
    int unsigned m;
    int unsigned y;
    int unsigned len;
    int unsigned left;
    int unsigned i;
    bit          ovf;
    bit          bad;
    d = r.day;
    m = r.month;
    y = r.year;
    ovf = 1'b0;
    bad = 1'b0;
    len = days_in(m, y);
    if (d == 0 || d > len) begin
      bad = 1'b1;
    end else if (r.kind == REQ_DAYS || r.kind == REQ_WEEKS) begin
      left = (r.kind == REQ_WEEKS) ? int'(r.amount) * 7 : int'(r.amount);
      while (left > 0) begin
        len = days_in(m, y);
        if (d + left <= len) begin
          d = d + left;
          left = 0;
        end else begin
          left = left - (len - d + 1);
          d = 1;
          if (m == LAST_MONTH) begin
            if (y == YEAR_MAX) begin
              d = LAST_DAY_DEC;
              ovf = 1'b1;
              left = 0;
            end else begin
              y++;
              m = 1;
            end
          end else begin
            m++;
          end
        end
      end
    end else if (r.kind == REQ_MONTHS) begin
      for (i = 0; i < r.amount && !ovf; i++) begin
        if (m == LAST_MONTH) begin
          if (y == YEAR_MAX) begin
            ovf = 1'b1;
          end else begin
            y++;
            m = 1;
          end
        end else begin
          m++;
        end
        if (!ovf && d > days_in(m, y)) begin
          d = days_in(m, y);
        end
      end
    end else begin
      if (r.amount > YEAR_MAX - y) begin
        y = YEAR_MAX;
        ovf = 1'b1;
      end else begin
        y = y + r.amount;
      end
    end
    res.day = 5'(d);
    res.month = 4'(m);
    res.year = YEAR_BITS'(y);
    res.overflow = ovf;
    res.bad = bad;
    return res;
  endfunction

  function automatic date_req_t make_req(req_type_t kind, int unsigned amount,
                                         int unsigned d, int unsigned m,
                                         int unsigned y);
    date_req_t r;
    r.kind = kind;
    r.amount = 15'(amount);
    r.day = 5'(d);
    r.month = 4'(m);
    r.year = YEAR_BITS'(y);
    r.drain_first = 1'b0;
    return r;
  endfunction

  // Long day and month walks cost many cycles, so large amounts are rare.
  function automatic int unsigned pick_amount(req_type_t kind);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (kind)
      REQ_DAYS:   return (roll < 5) ? $urandom_range(0, AMOUNT_MAX) : $urandom_range(0, 1500);
      REQ_WEEKS:  return (roll < 3) ? $urandom_range(0, AMOUNT_MAX) : $urandom_range(0, 300);
      REQ_MONTHS: return (roll < 2) ? AMOUNT_MAX - $urandom_range(0, 100)
                                    : $urandom_range(0, 200);
      default:    return $urandom_range(0, AMOUNT_MAX);
    endcase
  endfunction

  task automatic flag_error(string what);
    if (error_count < MAX_PRINTED) begin
      $display("ERROR at %0t: %s", $realtime, what);
    end
    error_count++;
  endtask

  // Request driver: holds the payload while stalled, then may idle a burst.
  always @(posedge clk) begin : drive_req
    date_req_t nxt;
    date_req_t taken;
    if (!rst_n) begin
      in_valid <= 1'b0;
      sender_gap <= 0;
    end else begin
      quiet_tail <= (pending_reqs.size() <= TAIL_REQS);
      if (in_valid && !in_stall) begin
        taken.kind = req_type_t'(in_req_type);
        taken.amount = in_amount;
        taken.day = in_start_day;
        taken.month = in_start_month;
        taken.year = in_start_year;
        taken.drain_first = 1'b0;
        expected_dates.push_back(advance_date(taken));
        reqs_taken <= reqs_taken + 1;
      end
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (sender_gap != 0) begin
        sender_gap <= sender_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() == 0 ||
                   (pending_reqs[0].drain_first && expected_dates.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        nxt = pending_reqs.pop_front();
        in_req_type <= nxt.kind;
        in_amount <= nxt.amount;
        in_start_day <= nxt.day;
        in_start_month <= nxt.month;
        in_start_year <= nxt.year;
        in_valid <= 1'b1;
        if (!quiet_tail && (pending_reqs.size() % 100) < 60 && $urandom_range(0, 2) == 0) begin
          sender_gap <= $urandom_range(1, 8);
        end
      end
    end
  end

  // Result stall: short random bursts, and once a long hold so that the
  // output register fills and the block stalls its input.
  always @(posedge clk) begin : drive_stall
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      stall_tick <= 0;
    end else begin
      stall_tick <= stall_tick + 1;
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (!long_hold_done && out_valid && stall_tick > HOLD_AFTER) begin
        stall_left <= LONG_HOLD - 1;
        long_hold_done <= 1'b1;
        out_stall <= 1'b1;
      end else if (!quiet_tail && stall_tick[9] && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 7);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_result
    date_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      bad_seen <= bad_seen + out_bad_date;
      overflow_seen <= overflow_seen + out_year_overflow;
      if (expected_dates.size() == 0) begin
        flag_error($sformatf("result %0d/%0d/%0d with no request outstanding",
                             out_new_day, out_new_month, out_new_year));
      end else begin
        want = expected_dates.pop_front();
        if (out_new_day !== want.day) begin
          flag_error($sformatf("new_day %0d, expected %0d", out_new_day, want.day));
        end
        if (out_new_month !== want.month) begin
          flag_error($sformatf("new_month %0d, expected %0d", out_new_month, want.month));
        end
        if (out_new_year !== want.year) begin
          flag_error($sformatf("new_year %0d, expected %0d", out_new_year, want.year));
        end
        if (out_year_overflow !== want.overflow) begin
          flag_error($sformatf("year_overflow %b, expected %b",
                               out_year_overflow, want.overflow));
        end
        if (out_bad_date !== want.bad) begin
          flag_error($sformatf("bad_date %b, expected %b", out_bad_date, want.bad));
        end
      end
    end
  end

  // Ends the run when neither channel has moved a transaction for too long.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : run_ctl
    req_type_t   kind;
    int unsigned d;
    int unsigned m;
    int unsigned y;
    int unsigned len;
    int unsigned n;

    // Directed: month, year and century boundaries, clamping, saturation
    // and malformed start dates.
    pending_reqs.push_back(make_req(REQ_DAYS, 0, 17, 5, 2021));
    pending_reqs.push_back(make_req(REQ_DAYS, 1, 31, 12, 1999));
    pending_reqs.push_back(make_req(REQ_DAYS, 1, 28, 2, 2000));
    pending_reqs.push_back(make_req(REQ_DAYS, 1, 28, 2, 1900));
    pending_reqs.push_back(make_req(REQ_DAYS, 1, 28, 2, 2024));
    pending_reqs.push_back(make_req(REQ_DAYS, 1, 28, 2, 2100));
    pending_reqs.push_back(make_req(REQ_DAYS, 365, 29, 2, 2000));
    pending_reqs.push_back(make_req(REQ_DAYS, AMOUNT_MAX, 1, 1, 0));
    pending_reqs.push_back(make_req(REQ_WEEKS, AMOUNT_MAX, 15, 6, 2000));
    pending_reqs.push_back(make_req(REQ_WEEKS, 1, 25, 12, YEAR_MAX));
    pending_reqs.push_back(make_req(REQ_DAYS, 1, 31, 12, YEAR_MAX));
    pending_reqs.push_back(make_req(REQ_MONTHS, 1, 31, 1, 2023));
    pending_reqs.push_back(make_req(REQ_MONTHS, 1, 31, 1, 2024));
    pending_reqs.push_back(make_req(REQ_MONTHS, 13, 31, 3, 2023));
    pending_reqs.push_back(make_req(REQ_MONTHS, 1, 15, 12, YEAR_MAX));
    pending_reqs.push_back(make_req(REQ_MONTHS, AMOUNT_MAX, 31, 12, 0));
    pending_reqs.push_back(make_req(REQ_MONTHS, AMOUNT_MAX, 30, 1, YEAR_MAX - 5));
    pending_reqs.push_back(make_req(REQ_YEARS, AMOUNT_MAX, 1, 1, YEAR_MAX));
    pending_reqs.push_back(make_req(REQ_YEARS, AMOUNT_MAX, 29, 2, 2000));
    pending_reqs.push_back(make_req(REQ_YEARS, 0, 31, 12, YEAR_MAX));
    pending_reqs.push_back(make_req(REQ_YEARS, AMOUNT_MAX, 1, 1, YEAR_MAX - AMOUNT_MAX));
    pending_reqs.push_back(make_req(REQ_DAYS, 10, 0, 1, 2000));
    pending_reqs.push_back(make_req(REQ_WEEKS, 3, 31, 4, 2010));
    pending_reqs.push_back(make_req(REQ_MONTHS, 2, 31, 0, 2000));
    pending_reqs.push_back(make_req(REQ_DAYS, 2, 31, 13, 2000));
    pending_reqs.push_back(make_req(REQ_YEARS, AMOUNT_MAX, 31, 15, YEAR_MAX));
    pending_reqs.push_back(make_req(REQ_DAYS, 5, 29, 2, 1900));
    directed_reqs = pending_reqs.size();

    for (n = 0; n < RANDOM_REQS; n++) begin
      kind = req_type_t'($urandom_range(0, 3));
      if ($urandom_range(0, 99) < 90) begin
        case ($urandom_range(0, 4))
          0: y = $urandom_range(0, YEAR_MAX);
          1: y = YEAR_MAX - $urandom_range(0, 2);
          2: y = $urandom_range(0, 655) * 100 + $urandom_range(0, 4);
          3: y = $urandom_range(1580, 2600);
          default: y = $urandom_range(0, 8);
        endcase
        m = $urandom_range(1, LAST_MONTH);
        len = days_in(m, y);
        d = ($urandom_range(0, 2) == 0) ? $urandom_range(len - 2, len)
                                        : $urandom_range(1, len);
      end else begin
        y = $urandom_range(0, YEAR_MAX);
        m = $urandom_range(0, 15);
        d = $urandom_range(0, 31);
      end
      pending_reqs.push_back(make_req(kind, pick_amount(kind), d, m, y));
    end
    // Once in mid-run the sender waits for every outstanding result.
    pending_reqs[directed_reqs + RANDOM_REQS / 2].drain_first = 1'b1;
    total_reqs = pending_reqs.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (reqs_taken != total_reqs) @(posedge clk);
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d date requests (%0d directed) over all four units.",
             total_reqs, directed_reqs);
    $display("Saw %0d results: %0d flagged bad, %0d with year saturation.",
             results_seen, bad_seen, overflow_seen);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", error_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/gda_pkg.sv
rtl/gda_mod25.sv
rtl/gregorian_date_adder.sv
bench/tb_top.sv
